FILE: sv/crot_pkg.sv
// types, constants and the arctangent table shared by the coordinate rotation block
package crot_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
    localparam int CORDIC_WIDTH   = 32;
    localparam int CORDIC_STEPS   = 24;
    localparam int TRIG_WIDTH     = 18;
    localparam int TRIG_SHIFT     = 14;
    localparam int PROD_WIDTH     = DIFF_WIDTH + TRIG_WIDTH;
    localparam int ACC_WIDTH      = PROD_WIDTH + 1;
    localparam int ROUND_SHIFT    = 16;
    localparam int ROUND_WIDTH    = ACC_WIDTH - ROUND_SHIFT;
    localparam int SUM_WIDTH      = ROUND_WIDTH + 1;

    typedef logic signed [COORD_WIDTH-1:0]  coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]   diff_t;
    typedef logic signed [CORDIC_WIDTH-1:0] cordic_t;
    typedef logic signed [CORDIC_WIDTH:0]   tround_t;
    typedef logic signed [TRIG_WIDTH-1:0]   trig_t;
    typedef logic signed [PROD_WIDTH-1:0]   prod_t;
    typedef logic signed [ACC_WIDTH-1:0]    acc_t;
    typedef logic signed [SUM_WIDTH-1:0]    sum_t;
    typedef logic [1:0]                     quad_t;

    localparam quad_t QUAD_0 = 2'd0;
    localparam quad_t QUAD_1 = 2'd1;
    localparam quad_t QUAD_2 = 2'd2;
    localparam quad_t QUAD_3 = 2'd3;

    localparam cordic_t CORDIC_GAIN = 32'sh26DD3B6A;
    localparam tround_t TRIG_HALF   = tround_t'(1) <<< (TRIG_SHIFT - 1);
    localparam acc_t    ACC_HALF    = acc_t'(1) <<< (ROUND_SHIFT - 1);
    localparam sum_t    SUM_MAX     = sum_t'((2 ** (COORD_WIDTH - 1)) - 1);
    localparam sum_t    SUM_MIN     = sum_t'(-(2 ** (COORD_WIDTH - 1)));
    localparam coord_t  COORD_MAX   = coord_t'((2 ** (COORD_WIDTH - 1)) - 1);
    localparam coord_t  COORD_MIN   = coord_t'(-(2 ** (COORD_WIDTH - 1)));

    typedef struct packed {
        diff_t  dx;
        diff_t  dy;
        coord_t cx;
        coord_t cy;
    } geo_t;

    typedef struct packed {
        geo_t  geo;
        quad_t quad;
    } side_t;

    typedef struct packed {
        geo_t  geo;
        trig_t cos_v;
        trig_t sin_v;
    } trig_word_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic cordic_t atan_turn(input int unsigned step);
        cordic_t val;
        unique case (step)
            0:       val = 32'sh20000000;
            1:       val = 32'sh12E4051E;
            2:       val = 32'sh09FB385B;
            3:       val = 32'sh051111D4;
            4:       val = 32'sh028B0D43;
            5:       val = 32'sh0145D7E1;
            6:       val = 32'sh00A2F61E;
            7:       val = 32'sh00517C55;
            8:       val = 32'sh0028BE53;
            9:       val = 32'sh00145F2F;
            10:      val = 32'sh000A2F98;
            11:      val = 32'sh000517CC;
            12:      val = 32'sh00028BE6;
            13:      val = 32'sh000145F3;
            14:      val = 32'sh0000A2FA;
            15:      val = 32'sh0000517D;
            16:      val = 32'sh000028BE;
            17:      val = 32'sh0000145F;
            18:      val = 32'sh00000A30;
            19:      val = 32'sh00000518;
            20:      val = 32'sh0000028C;
            21:      val = 32'sh00000146;
            22:      val = 32'sh000000A3;
            23:      val = 32'sh00000051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: sv/crot_cordic.sv
// pipelined cordic giving cosine and sine with quadrant fold and rounding
module crot_cordic (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  crot_pkg::side_t         side_in,
    input  crot_pkg::cordic_t       z_in,
    output logic                    valid_out,
    output crot_pkg::trig_word_t    word_out
);
    import crot_pkg::*;

    logic       valid_reg [0:CORDIC_STEPS];
    cordic_t    x_reg     [0:CORDIC_STEPS];
    cordic_t    y_reg     [0:CORDIC_STEPS];
    cordic_t    z_reg     [0:CORDIC_STEPS-1];
    side_t      side_reg  [0:CORDIC_STEPS];

    logic       trig_valid_reg;
    trig_word_t trig_reg;
    trig_word_t trig_next;
    cordic_t    cos_full;
    cordic_t    sin_full;
    tround_t    cos_round;
    tround_t    sin_round;

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= CORDIC_GAIN;
        y_reg[0]    <= '0;
        z_reg[0]    <= z_in;
        side_reg[0] <= side_in;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam cordic_t STEP_ANGLE = atan_turn(i);
        cordic_t xs;
        cordic_t ys;
        logic    rot_up;

        assign xs     = x_reg[i] >>> i;
        assign ys     = y_reg[i] >>> i;
        assign rot_up = ~z_reg[i][CORDIC_WIDTH-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rot_up)
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
            end
            side_reg[i+1] <= side_reg[i];
        end

        if (i < CORDIC_STEPS - 1)
        begin : g_angle
            always_ff @(posedge clk)
            begin
                if (rot_up)
                begin
                    z_reg[i+1] <= z_reg[i] - STEP_ANGLE;
                end
                else
                begin
                    z_reg[i+1] <= z_reg[i] + STEP_ANGLE;
                end
            end
        end
    end

    // quadrant fold and rounding to 16 fraction bits
    always_comb
    begin
        unique case (side_reg[CORDIC_STEPS].quad)
            QUAD_1:
            begin
                cos_full = -y_reg[CORDIC_STEPS];
                sin_full = x_reg[CORDIC_STEPS];
            end
            QUAD_2:
            begin
                cos_full = -x_reg[CORDIC_STEPS];
                sin_full = -y_reg[CORDIC_STEPS];
            end
            QUAD_3:
            begin
                cos_full = y_reg[CORDIC_STEPS];
                sin_full = -x_reg[CORDIC_STEPS];
            end
            default:
            begin
                cos_full = x_reg[CORDIC_STEPS];
                sin_full = y_reg[CORDIC_STEPS];
            end
        endcase
        cos_round       = (tround_t'(cos_full) + TRIG_HALF) >>> TRIG_SHIFT;
        sin_round       = (tround_t'(sin_full) + TRIG_HALF) >>> TRIG_SHIFT;
        trig_next.geo   = side_reg[CORDIC_STEPS].geo;
        trig_next.cos_v = cos_round[TRIG_WIDTH-1:0];
        trig_next.sin_v = sin_round[TRIG_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_valid_reg <= 1'b0;
        end
        else
        begin
            trig_valid_reg <= valid_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        trig_reg <= trig_next;
    end

    assign valid_out = trig_valid_reg;
    assign word_out  = trig_reg;

endmodule

FILE: sv/crot_mac.sv
// products, rounding, center add and saturation for the rotated coordinate
module crot_mac (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  crot_pkg::trig_word_t    word_in,
    output logic                    valid_out,
    output crot_pkg::coord_t        x_rot,
    output crot_pkg::coord_t        y_rot
);
    import crot_pkg::*;

    // product stage
    logic   prod_valid_reg;
    prod_t  xc_reg;
    prod_t  ys_reg;
    prod_t  yc_reg;
    prod_t  xs_reg;
    coord_t pcx_reg;
    coord_t pcy_reg;

    // sum stage
    logic   sum_valid_reg;
    sum_t   xsum_reg;
    sum_t   ysum_reg;
    sum_t   xsum_next;
    sum_t   ysum_next;
    acc_t   xacc;
    acc_t   yacc;

    // output stage
    logic   out_valid_reg;
    coord_t xout_reg;
    coord_t yout_reg;
    coord_t xout_next;
    coord_t yout_next;

    always_ff @(posedge clk)
    begin
        xc_reg  <= prod_t'(word_in.geo.dx) * prod_t'(word_in.cos_v);
        ys_reg  <= prod_t'(word_in.geo.dy) * prod_t'(word_in.sin_v);
        yc_reg  <= prod_t'(word_in.geo.dy) * prod_t'(word_in.cos_v);
        xs_reg  <= prod_t'(word_in.geo.dx) * prod_t'(word_in.sin_v);
        pcx_reg <= word_in.geo.cx;
        pcy_reg <= word_in.geo.cy;
    end

    always_comb
    begin
        xacc      = (acc_t'(xc_reg) + acc_t'(ys_reg) + ACC_HALF) >>> ROUND_SHIFT;
        yacc      = (acc_t'(yc_reg) - acc_t'(xs_reg) + ACC_HALF) >>> ROUND_SHIFT;
        xsum_next = sum_t'($signed(xacc[ROUND_WIDTH-1:0])) + sum_t'(pcx_reg);
        ysum_next = sum_t'($signed(yacc[ROUND_WIDTH-1:0])) + sum_t'(pcy_reg);
    end

    always_ff @(posedge clk)
    begin
        xsum_reg <= xsum_next;
        ysum_reg <= ysum_next;
    end

    always_comb
    begin
        priority if (xsum_reg > SUM_MAX)
            xout_next = COORD_MAX;
        else if (xsum_reg < SUM_MIN)
            xout_next = COORD_MIN;
        else
            xout_next = xsum_reg[COORD_WIDTH-1:0];

        priority if (ysum_reg > SUM_MAX)
            yout_next = COORD_MAX;
        else if (ysum_reg < SUM_MIN)
            yout_next = COORD_MIN;
        else
            yout_next = ysum_reg[COORD_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        xout_reg <= xout_next;
        yout_reg <= yout_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= valid_in;
            sum_valid_reg  <= prod_valid_reg;
            out_valid_reg  <= sum_valid_reg;
        end
    end

    assign valid_out = out_valid_reg;
    assign x_rot     = xout_reg;
    assign y_rot     = yout_reg;

endmodule

FILE: sv/coordinate_rotate_about_center.sv
// Rotates a Q8.16 coordinate about a center point by an angle given as a fraction of a
// turn (one half means no rotation). Fully pipelined: a new word is taken on every
// clock, so busy is always low, and each result appears with a one-cycle done strobe.
// The pipeline is the 24-step cordic (one step per stage) plus entry, quadrant fold,
// multiply, sum and saturate stages. The receiver cannot stall the pipeline; results
// must be taken in the cycle done is high.
module coordinate_rotate_about_center #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  crot_pkg::coord_t        x_in,
    input  crot_pkg::coord_t        y_in,
    input  crot_pkg::coord_t        center_x,
    input  crot_pkg::coord_t        center_y,
    input  logic [ANGLE_BITS-1:0]   angle_turn,
    output logic                    done,
    output crot_pkg::coord_t        x_out,
    output crot_pkg::coord_t        y_out
);
    import crot_pkg::*;

    localparam int RESID_BITS = CORDIC_WIDTH - 2;

    logic [ANGLE_BITS-1:0] phase;
    logic [RESID_BITS-1:0] resid;
    side_t                 side_in;
    cordic_t               z_in;
    logic                  trig_valid;
    trig_word_t            trig_word;

    // shift so that one half turn maps to zero angle
    assign phase = angle_turn ^ {1'b1, {(ANGLE_BITS-1){1'b0}}};
    assign resid = {phase[ANGLE_BITS-3:0], {(CORDIC_WIDTH-ANGLE_BITS){1'b0}}};
    assign z_in  = cordic_t'({2'b00, resid});

    assign side_in.quad   = phase[ANGLE_BITS-1:ANGLE_BITS-2];
    assign side_in.geo.dx = diff_t'(x_in) - diff_t'(center_x);
    assign side_in.geo.dy = diff_t'(y_in) - diff_t'(center_y);
    assign side_in.geo.cx = center_x;
    assign side_in.geo.cy = center_y;

    assign busy = 1'b0;

    crot_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start & ~busy),
        .side_in   (side_in),
        .z_in      (z_in),
        .valid_out (trig_valid),
        .word_out  (trig_word)
    );

    crot_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (trig_valid),
        .word_in   (trig_word),
        .valid_out (done),
        .x_rot     (x_out),
        .y_rot     (y_out)
    );

endmodule
